@@ sv/three_channel_timer_unit_defines.svh @@
// assertion macros shared by the timer unit modules
`ifndef THREE_CHANNEL_TIMER_UNIT_DEFINES_SVH
`define THREE_CHANNEL_TIMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer unit check failed");

// next-cycle implication, sampled on clk, off during rst
`define TCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer unit check failed");

`endif

@@ sv/tcu_pkg.sv @@
// shared types, register map and helpers of the timer unit
package tcu_pkg;

  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OFS_W       = 8;
  localparam int unsigned UNDERFLOW_BIT = 8;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } tcu_kind_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } tcu_size_t;

  // register map
  localparam logic [OFS_W-1:0] OFS_OUT_CTRL = 8'h00;
  localparam logic [OFS_W-1:0] OFS_START    = 8'h04;
  localparam logic [OFS_W-1:0] OFS_CAPTURE  = 8'h2c;
  localparam logic [OFS_W-1:0] OFS_RELOAD [NUM_CH] = '{8'h08, 8'h14, 8'h20};
  localparam logic [OFS_W-1:0] OFS_COUNT  [NUM_CH] = '{8'h0c, 8'h18, 8'h24};
  localparam logic [OFS_W-1:0] OFS_CTRL   [NUM_CH] = '{8'h10, 8'h1c, 8'h28};

  localparam logic [DATA_W-1:0] COUNT_RESET = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] STEP_RESET  = 32'd1;

  // per-channel command from the decode stage
  typedef struct packed {
    logic              wr_reload;
    logic              wr_count;
    logic              wr_ctrl;
    logic              tick;
    logic              run;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] wmask;
  } tcu_ch_cmd_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    unique case (size)
      SIZE_BYTE: m = 32'h0000_00ff;
      SIZE_HALF: m = 32'h0000_ffff;
      default:   m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

@@ sv/tcu_if.sv @@
// handshake channels of the timer unit: bus item, result and step register
interface tcu_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [1:0]                 access_size;
  logic [tcu_pkg::OFS_W-1:0]  reg_offset;
  logic [tcu_pkg::DATA_W-1:0] write_data;
  modport source (output valid, kind, access_size, reg_offset, write_data, input ready);
  modport sink   (input valid, kind, access_size, reg_offset, write_data, output ready);
endinterface

interface tcu_result_if;
  logic                       valid;
  logic                       ready;
  logic [tcu_pkg::DATA_W-1:0] read_data;
  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface tcu_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tcu_pkg::DATA_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/tcu_channel.sv @@
// one down-counter channel: reload constant, counter and control register
`include "three_channel_timer_unit_defines.svh"

module tcu_channel (
  input  logic                       clk,
  input  logic                       rst,
  input  tcu_pkg::tcu_ch_cmd_t       cmd,
  input  logic [tcu_pkg::DATA_W-1:0] count_step,
  output logic [tcu_pkg::DATA_W-1:0] reload,
  output logic [tcu_pkg::DATA_W-1:0] count,
  output logic [15:0]                ctrl
);
  import tcu_pkg::*;

  logic [DATA_W:0] diff;
  logic            borrow;

  // borrow out means the counter wraps below zero
  assign diff   = {1'b0, count} - {1'b0, count_step};
  assign borrow = diff[DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= COUNT_RESET;
      count  <= COUNT_RESET;
      ctrl   <= '0;
    end else begin
      if (cmd.wr_reload) begin
        reload <= (reload & ~cmd.wmask) | (cmd.wdata & cmd.wmask);
      end
      if (cmd.wr_count) begin
        count <= (count & ~cmd.wmask) | (cmd.wdata & cmd.wmask);
      end
      if (cmd.wr_ctrl) begin
        ctrl <= (ctrl & ~cmd.wmask[15:0]) | (cmd.wdata[15:0] & cmd.wmask[15:0]);
      end
      if (cmd.tick && cmd.run) begin
        if (borrow) begin
          count                <= reload;
          ctrl[UNDERFLOW_BIT]  <= 1'b1;
        end else begin
          count <= diff[DATA_W-1:0];
        end
      end
    end
  end

  `TCU_ASSERT_NEXT(a_underflow_flag, cmd.tick && cmd.run && borrow, ctrl[UNDERFLOW_BIT])
  `TCU_ASSERT_NEXT(a_underflow_reload, cmd.tick && cmd.run && borrow, count == $past(reload))
  `TCU_ASSERT_NEXT(a_stopped_holds, cmd.tick && !cmd.run, count == $past(count))

endmodule

@@ sv/three_channel_timer_unit.sv @@
// Three-channel timer unit: three 32-bit down-counters behind a small register
// bus. Each word on the item channel is a register read, a register write, a
// tick or an unused kind code; every word yields exactly one result word (the
// read value masked to the access size, zero for all other kinds). Throughput
// is one word per cycle while the result side does not stall: an accepted word
// sits in the input register, where the register decode, the three counter
// subtractors and the read mux work in parallel, and its result is registered
// in the output register once that is free or draining. The output register
// lets a new word enter while a finished result still waits. count_step is
// written over the cfg channel, which is always ready.
`include "three_channel_timer_unit_defines.svh"

module three_channel_timer_unit (
  input  logic       clk,
  input  logic       rst,
  tcu_item_if.sink   item,
  tcu_result_if.source result,
  tcu_cfg_if.sink    cfg
);
  import tcu_pkg::*;

  // configuration
  logic [DATA_W-1:0] count_step;

  // input register
  logic              s1_valid;
  logic [1:0]        s1_kind;
  logic [1:0]        s1_size;
  logic [OFS_W-1:0]  s1_ofs;
  logic [DATA_W-1:0] s1_data;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_data;

  // global registers
  logic [7:0]        out_ctrl;
  logic [7:0]        start_bits;
  logic [DATA_W-1:0] capture;

  // channel state
  logic [DATA_W-1:0] ch_reload [NUM_CH];
  logic [DATA_W-1:0] ch_count  [NUM_CH];
  logic [15:0]       ch_ctrl   [NUM_CH];
  tcu_ch_cmd_t       ch_cmd    [NUM_CH];

  logic              s1_adv;
  logic              is_wr;
  logic              is_tick;
  logic [DATA_W-1:0] smask;
  logic [DATA_W-1:0] rd_val;
  logic [DATA_W-1:0] out_data_next;

  // input register moves on whenever the output register is free or draining
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign cfg.ready  = 1'b1;

  assign is_wr   = s1_adv && (s1_kind == KIND_WRITE);
  assign is_tick = s1_adv && (s1_kind == KIND_TICK);
  assign smask   = size_mask(s1_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_step <= STEP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      count_step <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind <= item.kind;
      s1_size <= item.access_size;
      s1_ofs  <= item.reg_offset;
      s1_data <= item.write_data;
    end
  end

  // per-channel decode; writes and ticks never coincide
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ch_cmd[i].wr_reload = is_wr && (s1_ofs == OFS_RELOAD[i]);
      ch_cmd[i].wr_count  = is_wr && (s1_ofs == OFS_COUNT[i]);
      ch_cmd[i].wr_ctrl   = is_wr && (s1_ofs == OFS_CTRL[i]);
      ch_cmd[i].tick      = is_tick;
      ch_cmd[i].run       = start_bits[i];
      ch_cmd[i].wdata     = s1_data;
      ch_cmd[i].wmask     = smask;
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    tcu_channel u_ch (
      .clk        (clk),
      .rst        (rst),
      .cmd        (ch_cmd[g]),
      .count_step (count_step),
      .reload     (ch_reload[g]),
      .count      (ch_count[g]),
      .ctrl       (ch_ctrl[g])
    );
  end

  // byte-wide and capture registers, partial writes keep untouched bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl   <= '0;
      start_bits <= '0;
      capture    <= '0;
    end else if (is_wr) begin
      if (s1_ofs == OFS_OUT_CTRL) begin
        out_ctrl <= (out_ctrl & ~smask[7:0]) | (s1_data[7:0] & smask[7:0]);
      end
      if (s1_ofs == OFS_START) begin
        start_bits <= (start_bits & ~smask[7:0]) | (s1_data[7:0] & smask[7:0]);
      end
      if (s1_ofs == OFS_CAPTURE) begin
        capture <= (capture & ~smask) | (s1_data & smask);
      end
    end
  end

  // read mux, unmapped offsets give zero
  always_comb begin
    rd_val = '0;
    if (s1_ofs == OFS_OUT_CTRL) begin
      rd_val = {24'd0, out_ctrl};
    end
    if (s1_ofs == OFS_START) begin
      rd_val = {24'd0, start_bits};
    end
    if (s1_ofs == OFS_CAPTURE) begin
      rd_val = capture;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      if (s1_ofs == OFS_RELOAD[i]) begin
        rd_val = ch_reload[i];
      end
      if (s1_ofs == OFS_COUNT[i]) begin
        rd_val = ch_count[i];
      end
      if (s1_ofs == OFS_CTRL[i]) begin
        rd_val = {16'd0, ch_ctrl[i]};
      end
    end
  end

  assign out_data_next = (s1_kind == KIND_READ) ? (rd_val & smask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= out_data_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.read_data = out_data;

  `TCU_ASSERT_NEXT(a_nonread_zero, s1_adv && (s1_kind != KIND_READ), out_data == '0)
  `TCU_ASSERT_NEXT(a_accept_loads, item.valid && item.ready, s1_valid)

endmodule

@@ test/timer_unit_checker.sv @@
// checker for the timer unit: mirrors the registers and counters, compares every result word
module timer_unit_checker (
  input  logic         clk,
  input  logic         rst,
  tcu_item_if          item,
  tcu_result_if        result,
  tcu_cfg_if           cfg,
  output int           mismatches,
  output int           outstanding,
  output int           wraps,
  output int           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcu_pkg::*;

  localparam logic [15:0] UNDERFLOW_FLAG = 16'h0001 << UNDERFLOW_BIT;

  // mirrored block state
  logic [DATA_W-1:0] step_amount;
  logic [7:0]        out_ctrl;
  logic [7:0]        start_mask;
  logic [DATA_W-1:0] reload_val [NUM_CH];
  logic [DATA_W-1:0] count_val  [NUM_CH];
  logic [15:0]       ctrl_val   [NUM_CH];
  logic [DATA_W-1:0] capture_val;

  // read data still owed by the block, oldest first
  logic [DATA_W-1:0] read_data_due [$];

  function automatic void clear_state();
    int i;
    step_amount = STEP_RESET;
    out_ctrl    = '0;
    start_mask  = '0;
    capture_val = '0;
    for (i = 0; i < NUM_CH; i++) begin
      reload_val[i] = COUNT_RESET;
      count_val[i]  = COUNT_RESET;
      ctrl_val[i]   = '0;
    end
  endfunction

  // value of the register at an offset; width_mask is zero where nothing is mapped
  function automatic logic [DATA_W-1:0] reg_value(input logic [OFS_W-1:0] ofs,
                                                  output logic [DATA_W-1:0] width_mask);
    logic [DATA_W-1:0] v;
    int i;
    v = '0;
    width_mask = '0;
    if (ofs == OFS_OUT_CTRL) begin
      v = {24'h0, out_ctrl};
      width_mask = 32'h0000_00ff;
    end else if (ofs == OFS_START) begin
      v = {24'h0, start_mask};
      width_mask = 32'h0000_00ff;
    end else if (ofs == OFS_CAPTURE) begin
      v = capture_val;
      width_mask = '1;
    end
    for (i = 0; i < NUM_CH; i++) begin
      if (ofs == OFS_RELOAD[i]) begin
        v = reload_val[i];
        width_mask = '1;
      end else if (ofs == OFS_COUNT[i]) begin
        v = count_val[i];
        width_mask = '1;
      end else if (ofs == OFS_CTRL[i]) begin
        v = {16'h0, ctrl_val[i]};
        width_mask = 32'h0000_ffff;
      end
    end
    return v;
  endfunction

  function automatic void reg_store(input logic [OFS_W-1:0] ofs, input logic [DATA_W-1:0] v);
    int i;
    if (ofs == OFS_OUT_CTRL) out_ctrl = v[7:0];
    else if (ofs == OFS_START) start_mask = v[7:0];
    else if (ofs == OFS_CAPTURE) capture_val = v;
    for (i = 0; i < NUM_CH; i++) begin
      if (ofs == OFS_RELOAD[i]) reload_val[i] = v;
      else if (ofs == OFS_COUNT[i]) count_val[i] = v;
      else if (ofs == OFS_CTRL[i]) ctrl_val[i] = v[15:0];
    end
  endfunction

  // applies one bus word to the mirror and returns the read data it yields
  function automatic logic [DATA_W-1:0] apply_bus_word(input logic [1:0] kind,
                                                       input logic [1:0] size,
                                                       input logic [OFS_W-1:0] ofs,
                                                       input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] cur, wmask, smask, m, nxt, rd;
    int i;
    rd = '0;
    case (size)
      SIZE_BYTE: smask = 32'h0000_00ff;
      SIZE_HALF: smask = 32'h0000_ffff;
      default:   smask = '1;
    endcase
    case (kind)
      KIND_READ: begin
        cur = reg_value(ofs, wmask);
        rd = cur & wmask & smask;
      end
      KIND_WRITE: begin
        cur = reg_value(ofs, wmask);
        if (wmask != '0) begin
          m = wmask & smask;
          reg_store(ofs, (cur & ~m) | (data & m));
        end
      end
      KIND_TICK: begin
        for (i = 0; i < NUM_CH; i++) begin
          if (start_mask[i]) begin
            nxt = count_val[i] - step_amount;
            // wrap below zero: reload and flag underflow
            if (nxt > count_val[i]) begin
              ctrl_val[i] = ctrl_val[i] | UNDERFLOW_FLAG;
              nxt = reload_val[i];
              wraps++;
            end
            count_val[i] = nxt;
          end
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      clear_state();
      read_data_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (read_data_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word 0x%08h arrived with none outstanding",
                     $realtime, result.read_data);
          mismatches++;
        end else begin
          want = read_data_due.pop_front();
          if (result.read_data !== want) begin
            if (mismatches < 10)
              $display("%0t: read_data mismatch: expected 0x%08h, got 0x%08h",
                       $realtime, want, result.read_data);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) step_amount = cfg.data;
      if (item.valid && item.ready)
        read_data_due.push_back(apply_bus_word(item.kind, item.access_size,
                                               item.reg_offset, item.write_data));
    end
    outstanding = read_data_due.size();
  end

endmodule

@@ test/testbench.sv @@
// top of the timer unit testbench: clock, reset, bus word stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcu_pkg::*;

  // no handshake of any kind for this long means the block is stuck
  localparam int unsigned IDLE_LIMIT  = 1000;
  // bus words per count step setting
  localparam int unsigned PHASE_WORDS = 54;

  // codes outside the named ones, still legal on the wires
  localparam logic [1:0]        KIND_NONE  = 2'd3;
  localparam logic [1:0]        SIZE_CODE3 = 2'd3;
  localparam logic [OFS_W-1:0]  OFS_HOLE   = 8'h30;
  localparam logic [OFS_W-1:0]  OFS_TOP    = 8'hff;
  localparam logic [DATA_W-1:0] UNDERFLOW_MASK = 32'h1 << UNDERFLOW_BIT;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcu_item_if   item_ch ();
  tcu_result_if result_ch ();
  tcu_cfg_if    cfg_ch ();

  three_channel_timer_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  int mismatches;
  int outstanding;
  int wraps;
  int results_seen;

  // watches all three channels, predicts and compares
  timer_unit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .wraps        (wraps),
    .results_seen (results_seen)
  );

  logic item_acc = 1'b0;
  logic cfg_acc  = 1'b0;
  int   idle_cycles = 0;
  int   words_sent = 0;
  int   step_settings = 1;
  int   ready_hold = 0;
  bit   gaps_on = 1'b0;
  bit   stalls_on = 1'b0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshakes registered at the rising edge, read by the drivers at the falling edge
  always @(posedge clk) begin
    item_acc <= item_ch.valid && item_ch.ready;
    cfg_acc  <= cfg_ch.valid && cfg_ch.ready;
  end

  // watchdog: counts cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, outstanding);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure: mostly short stalls, a few long ones, none when stalls_on is low
  always @(negedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (!stalls_on) begin
      result_ch.ready = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        result_ch.ready = 1'b1;
        ready_hold = $urandom_range(0, 4);
      end else if (r < 93) begin
        result_ch.ready = 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        result_ch.ready = 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  // sender gap in cycles: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one of the twelve mapped, aligned offsets
  function automatic logic [OFS_W-1:0] pick_mapped_ofs();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0: return OFS_OUT_CTRL;
      1: return OFS_START;
      2: return OFS_CAPTURE;
      default: begin
        case ((r - 3) / 3)
          0: return OFS_RELOAD[(r - 3) % 3];
          1: return OFS_COUNT[(r - 3) % 3];
          default: return OFS_CTRL[(r - 3) % 3];
        endcase
      end
    endcase
  endfunction

  // present one bus word and hold it until the block takes it; returns on a falling edge
  task automatic send_word(input logic [1:0] kind, input logic [1:0] size,
                           input logic [OFS_W-1:0] ofs, input logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.kind        = kind;
    item_ch.access_size = size;
    item_ch.reg_offset  = ofs;
    item_ch.write_data  = data;
    item_ch.valid       = 1'b1;
    do @(negedge clk); while (!item_acc);
    words_sent++;
  endtask

  // sender holds off until every result word has come back
  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // new count step, only with the block idle
  task automatic write_step(input logic [DATA_W-1:0] value);
    wait_drained();
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(negedge clk); while (!cfg_acc);
    cfg_ch.valid = 1'b0;
    step_settings++;
  endtask

  // program one channel with small values, run it and watch it wrap
  task automatic run_channel_scenario();
    int ch;
    int n;
    int r;
    logic [DATA_W-1:0] flag_data;
    ch = $urandom_range(0, 2);
    send_word(KIND_WRITE, SIZE_WORD, OFS_RELOAD[ch],
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
    send_word(KIND_WRITE, SIZE_WORD, OFS_COUNT[ch], $urandom_range(0, 25));
    send_word(KIND_WRITE, SIZE_BYTE, OFS_START, $urandom_range(0, 255) | (1 << ch));
    n = $urandom_range(2, 14);
    repeat (n) begin
      r = $urandom_range(0, 9);
      // tick fields other than kind carry junk, the block must ignore it
      if (r < 6)
        send_word(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
      else if (r < 8)
        send_word(KIND_READ, 2'($urandom_range(0, 3)), OFS_COUNT[ch], $urandom);
      else
        send_word(KIND_READ, 2'($urandom_range(0, 3)), OFS_CTRL[ch], $urandom);
    end
    send_word(KIND_READ, SIZE_HALF, OFS_CTRL[ch], '0);
    // software clears the underflow flag, or sometimes sets it back
    if ($urandom_range(0, 2) != 0) begin
      flag_data = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & ~UNDERFLOW_MASK);
      send_word(KIND_WRITE, 2'($urandom_range(0, 3)), OFS_CTRL[ch], flag_data);
    end
  endtask

  // anything the fields allow: unmapped and unaligned offsets, odd codes, extreme data
  task automatic send_noise_word();
    int r;
    logic [OFS_W-1:0] ofs;
    logic [DATA_W-1:0] data;
    r = $urandom_range(0, 9);
    if (r < 5) ofs = pick_mapped_ofs();
    else if (r < 8) ofs = 8'($urandom_range(0, 47));
    else ofs = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: data = '0;
      1: data = '1;
      default: data = $urandom;
    endcase
    send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), ofs, data);
  endtask

  task automatic run_random_phase(input int target);
    int r;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 3) wait_drained();
      else if (r < 68) run_channel_scenario();
      else send_noise_word();
    end
  endtask

  initial begin
    logic [DATA_W-1:0] step_plan [7];
    int ph;

    // every input known from time zero
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_READ;
    item_ch.access_size = SIZE_WORD;
    item_ch.reg_offset  = '0;
    item_ch.write_data  = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    result_ch.ready     = 1'b0;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed part, gaps and stalls already on
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    // reset values of counter and reload
    send_word(KIND_READ,  SIZE_WORD,  OFS_COUNT[2],  '0);
    send_word(KIND_READ,  SIZE_WORD,  OFS_RELOAD[1], '0);
    // wide write to a byte register, read back zero-extended
    send_word(KIND_WRITE, SIZE_WORD,  OFS_OUT_CTRL,  32'hffff_ffff);
    send_word(KIND_READ,  SIZE_WORD,  OFS_OUT_CTRL,  '0);
    // partial write keeps the upper bytes
    send_word(KIND_WRITE, SIZE_BYTE,  OFS_RELOAD[0], 32'h1234_56a5);
    send_word(KIND_READ,  SIZE_HALF,  OFS_RELOAD[0], '0);
    // halfword into the 16-bit control register, byte read
    send_word(KIND_WRITE, SIZE_HALF,  OFS_CTRL[1],   32'h1234_5678);
    send_word(KIND_READ,  SIZE_BYTE,  OFS_CTRL[1],   '0);
    // size code 3 acts as word
    send_word(KIND_WRITE, SIZE_CODE3, OFS_CAPTURE,   32'hdead_beef);
    send_word(KIND_READ,  SIZE_CODE3, OFS_CAPTURE,   '0);
    // unmapped and unaligned offsets
    send_word(KIND_WRITE, SIZE_WORD,  OFS_HOLE,      32'hffff_ffff);
    send_word(KIND_READ,  SIZE_WORD,  OFS_HOLE,      '0);
    send_word(KIND_READ,  SIZE_WORD,  OFS_RELOAD[0] + 8'd1, '0);
    send_word(KIND_WRITE, SIZE_WORD,  OFS_COUNT[0] + 8'd2,  32'h0);
    // kind code 3 does nothing
    send_word(KIND_NONE,  SIZE_WORD,  OFS_CAPTURE,   32'h0);
    // start bits 3 to 7 are stored but run no channel
    send_word(KIND_WRITE, SIZE_BYTE,  OFS_START,     32'h0000_00f8);
    send_word(KIND_TICK,  SIZE_WORD,  OFS_TOP,       32'hffff_ffff);
    send_word(KIND_READ,  SIZE_WORD,  OFS_START,     '0);
    send_word(KIND_READ,  SIZE_WORD,  OFS_COUNT[0],  '0);
    // channel 0 from 1 with reload 7: second tick wraps and flags underflow
    send_word(KIND_WRITE, SIZE_WORD,  OFS_COUNT[0],  32'h1);
    send_word(KIND_WRITE, SIZE_WORD,  OFS_RELOAD[0], 32'h7);
    send_word(KIND_WRITE, SIZE_BYTE,  OFS_START,     32'h1);
    send_word(KIND_TICK,  SIZE_BYTE,  '0,            '0);
    send_word(KIND_TICK,  SIZE_BYTE,  '0,            '0);
    send_word(KIND_READ,  SIZE_HALF,  OFS_CTRL[0],   '0);
    // software clears the flag; top offset reads as zero
    send_word(KIND_WRITE, SIZE_HALF,  OFS_CTRL[0],   32'h0);
    send_word(KIND_READ,  SIZE_WORD,  OFS_TOP,       '0);

    // count step settings: reset value first, then the extremes and a few in between
    step_plan[0] = STEP_RESET;
    step_plan[1] = 32'hffff_ffff;
    step_plan[2] = 32'h0;
    step_plan[3] = 32'h1;
    step_plan[4] = $urandom_range(2, 7);
    step_plan[5] = $urandom_range(8, 300);
    step_plan[6] = $urandom | 32'h8000_0000;

    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_step(step_plan[ph]);
      // one phase without sender gaps, another without result stalls
      gaps_on   = (ph != 3);
      stalls_on = (ph != 2);
      run_random_phase(words_sent + PHASE_WORDS);
    end

    // drain, then let the pipeline settle
    wait_drained();
    repeat (6) @(negedge clk);

    $display("run: %0d bus words sent, %0d result words checked", words_sent, results_seen);
    $display("run: %0d counter wraps across %0d count step settings", wraps, step_settings);
    if (outstanding != 0)
      $display("%0d result words never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ three_channel_timer_unit.f @@
+incdir+sv
sv/tcu_pkg.sv
sv/tcu_if.sv
sv/tcu_channel.sv
sv/three_channel_timer_unit.sv
test/timer_unit_checker.sv
test/testbench.sv
